// ----- rtl/sgtr_pkg.sv -----
// Package for the scaled glyph text renderer: request/response word types,
// register indexes and the 5x8 column font table.
// No dependencies.
`default_nettype none

package sgtr_pkg;

   localparam logic [7:0] NewlineCode = 8'd10;
   localparam logic [7:0] GlyphFirst  = 8'd32;
   localparam logic [7:0] GlyphLast   = 8'd122;
   localparam logic [6:0] GlyphSubst  = 7'd31;   // '?' minus first printable code

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 16;
   localparam logic [CsrIndexWidth-1:0] CsrForegroundColor = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrBackgroundColor = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrPixelScale      = 2'd2;

   typedef struct packed {
      logic [7:0]  char_code;
      logic [15:0] start_x;
      logic [15:0] start_y;
      logic        first;
   } req_word_type;

   typedef struct packed {
      logic [15:0] cell_x;
      logic [15:0] cell_y;
      logic [7:0]  cell_width;
      logic [7:0]  cell_height;
      logic [15:0] cell_color;
      logic        visible;
      logic        last_cell;
   } rsp_word_type;

   // Columns 0..4 from the most significant byte down; bit 0 of a byte is the top row.
   function automatic logic [39:0] glyph_columns(input logic [6:0] idx);
      logic [39:0] g;
      case (idx)
         7'd0:  g = 40'h0000000000;
         7'd1:  g = 40'h00005F0000;
         7'd2:  g = 40'h0007000700;
         7'd3:  g = 40'h147F147F14;
         7'd4:  g = 40'h242A7F2A12;
         7'd5:  g = 40'h2313086462;
         7'd6:  g = 40'h3649552250;
         7'd7:  g = 40'h0005030000;
         7'd8:  g = 40'h001C224100;
         7'd9:  g = 40'h0041221C00;
         7'd10: g = 40'h14083E0814;
         7'd11: g = 40'h08083E0808;
         7'd12: g = 40'h0050300000;
         7'd13: g = 40'h0808080808;
         7'd14: g = 40'h0060600000;
         7'd15: g = 40'h2010080402;
         7'd16: g = 40'h3E5149453E;
         7'd17: g = 40'h00427F4000;
         7'd18: g = 40'h4261514946;
         7'd19: g = 40'h2141454B31;
         7'd20: g = 40'h1814127F10;
         7'd21: g = 40'h2745454539;
         7'd22: g = 40'h3C4A494930;
         7'd23: g = 40'h0171090503;
         7'd24: g = 40'h3649494936;
         7'd25: g = 40'h064949291E;
         7'd26: g = 40'h0036360000;
         7'd27: g = 40'h0056360000;
         7'd28: g = 40'h0814224100;
         7'd29: g = 40'h1414141414;
         7'd30: g = 40'h0041221408;
         7'd31: g = 40'h0201510906;
         7'd32: g = 40'h324979413E;
         7'd33: g = 40'h7E1111117E;
         7'd34: g = 40'h7F49494936;
         7'd35: g = 40'h3E41414122;
         7'd36: g = 40'h7F4141221C;
         7'd37: g = 40'h7F49494941;
         7'd38: g = 40'h7F09090901;
         7'd39: g = 40'h3E4149497A;
         7'd40: g = 40'h7F0808087F;
         7'd41: g = 40'h00417F4100;
         7'd42: g = 40'h2040413F01;
         7'd43: g = 40'h7F08142241;
         7'd44: g = 40'h7F40404040;
         7'd45: g = 40'h7F020C027F;
         7'd46: g = 40'h7F0408107F;
         7'd47: g = 40'h3E4141413E;
         7'd48: g = 40'h7F09090906;
         7'd49: g = 40'h3E4151215E;
         7'd50: g = 40'h7F09192946;
         7'd51: g = 40'h4649494931;
         7'd52: g = 40'h01017F0101;
         7'd53: g = 40'h3F4040403F;
         7'd54: g = 40'h1F2040201F;
         7'd55: g = 40'h3F4038403F;
         7'd56: g = 40'h6314081463;
         7'd57: g = 40'h0708700807;
         7'd58: g = 40'h6151494543;
         7'd59: g = 40'h007F414100;
         7'd60: g = 40'h0204081020;
         7'd61: g = 40'h0041417F00;
         7'd62: g = 40'h0402010204;
         7'd63: g = 40'h4040404040;
         7'd64: g = 40'h0001020400;
         7'd65: g = 40'h2054545478;
         7'd66: g = 40'h7F48444438;
         7'd67: g = 40'h3844444420;
         7'd68: g = 40'h384444487F;
         7'd69: g = 40'h3854545418;
         7'd70: g = 40'h087E090102;
         7'd71: g = 40'h0C5252523E;
         7'd72: g = 40'h7F08040478;
         7'd73: g = 40'h00447D4000;
         7'd74: g = 40'h2040443D00;
         7'd75: g = 40'h7F10284400;
         7'd76: g = 40'h00417F4000;
         7'd77: g = 40'h7C04180478;
         7'd78: g = 40'h7C08040478;
         7'd79: g = 40'h3844444438;
         7'd80: g = 40'h7C14141408;
         7'd81: g = 40'h081414187C;
         7'd82: g = 40'h7C08040408;
         7'd83: g = 40'h4854545420;
         7'd84: g = 40'h043F444020;
         7'd85: g = 40'h3C4040207C;
         7'd86: g = 40'h1C2040201C;
         7'd87: g = 40'h3C4030403C;
         7'd88: g = 40'h4428102844;
         7'd89: g = 40'h0C5050503C;
         7'd90: g = 40'h4464544C44;
         default: g = 40'h0000000000;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/scaled_glyph_text_renderer.sv -----
// Scaled glyph text renderer: one character word in, forty cell words out (none for a newline).
// Cell words go out one per cycle while the receiver takes them, made by the single cell
// generator stepping column by column.
// The next character is taken in the cycle its predecessor's last cell is produced.
// Reset (synchronous, active high) clears cursor, origin, control and loads register defaults.
// Depends on sgtr_pkg.
`default_nettype none

module scaled_glyph_text_renderer
   import sgtr_pkg::*;
#(
   parameter int unsigned SCREEN_WIDTH  = 320,
   parameter int unsigned SCREEN_HEIGHT = 480
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_word_type             req_word,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_word_type                  rsp_word,
   input  wire logic                     csr_wr_en,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   localparam logic [16:0] ScreenW = 17'(SCREEN_WIDTH);
   localparam logic [16:0] ScreenH = 17'(SCREEN_HEIGHT);

   // configuration registers
   logic [15:0] fg_color_ff;
   logic [15:0] bg_color_ff;
   logic [7:0]  scale_ff;

   // text position
   logic [15:0] cursor_col_ff, cursor_col_in;
   logic [15:0] cursor_row_ff, cursor_row_in;
   logic [15:0] origin_col_ff, origin_col_in;

   // cell generator
   logic        busy_ff, busy_in;
   logic [2:0]  col_cnt_ff, col_cnt_in;
   logic [2:0]  row_cnt_ff, row_cnt_in;
   logic [15:0] x_ff, x_in;
   logic [15:0] y_ff, y_in;
   logic [15:0] base_y_ff, base_y_in;
   logic [39:0] glyph_ff;          // registered font read, shifts one bit per cell
   logic [39:0] glyph_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic         accept, is_newline, printable, out_free, gen_fire, gen_last;
   logic [15:0]  eff_col, eff_row;
   logic [6:0]   glyph_idx;
   logic [39:0]  glyph_raw, glyph_ordered;
   logic [10:0]  advance;
   logic [16:0]  x_end, y_end, x_ext, y_ext;
   logic         on;
   rsp_word_type cell_word;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign gen_fire  = busy_ff && out_free;
   assign gen_last  = (col_cnt_ff == 3'd4) && (row_cnt_ff == 3'd7);
   assign req_ready = !busy_ff || (gen_fire && gen_last);
   assign accept    = req_valid && req_ready;

   assign eff_col    = req_word.first ? req_word.start_x : cursor_col_ff;
   assign eff_row    = req_word.first ? req_word.start_y : cursor_row_ff;
   assign is_newline = (req_word.char_code == NewlineCode);
   assign printable  = (req_word.char_code >= GlyphFirst) && (req_word.char_code <= GlyphLast);
   assign glyph_idx  = printable ? 7'(req_word.char_code - GlyphFirst) : GlyphSubst;
   assign glyph_raw  = glyph_columns(glyph_idx);
   assign advance    = {1'b0, scale_ff, 2'b00} + {2'b00, scale_ff, 1'b0};

   // reorder so column 0 sits in the low byte and bits leave LSB first
   always_comb begin
      for (int c = 0; c < 5; c++) begin
         glyph_ordered[c*8 +: 8] = glyph_raw[(4-c)*8 +: 8];
      end
   end

   // cell geometry and clipping
   assign x_ext = {1'b0, x_ff};
   assign y_ext = {1'b0, y_ff};
   assign x_end = x_ext + {9'd0, scale_ff};
   assign y_end = y_ext + {9'd0, scale_ff};
   assign on    = (x_ext < ScreenW) && (y_ext < ScreenH) && (scale_ff != 8'd0);

   always_comb begin
      cell_word.cell_x      = x_ff;
      cell_word.cell_y      = y_ff;
      cell_word.cell_width  = 8'd0;
      cell_word.cell_height = 8'd0;
      if (on) begin
         cell_word.cell_width  = (x_end > ScreenW) ? 8'(ScreenW - x_ext) : scale_ff;
         cell_word.cell_height = (y_end > ScreenH) ? 8'(ScreenH - y_ext) : scale_ff;
      end
      cell_word.cell_color = glyph_ff[0] ? fg_color_ff : bg_color_ff;
      cell_word.visible    = on;
      cell_word.last_cell  = gen_last;
   end

   always_comb begin
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      origin_col_in = origin_col_ff;
      busy_in       = busy_ff;
      col_cnt_in    = col_cnt_ff;
      row_cnt_in    = row_cnt_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      base_y_in     = base_y_ff;
      glyph_in      = glyph_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;

      if (gen_fire) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = cell_word;
         glyph_in     = {1'b0, glyph_ff[39:1]};
         if (row_cnt_ff == 3'd7) begin
            row_cnt_in = 3'd0;
            col_cnt_in = col_cnt_ff + 3'd1;
            x_in       = x_ff + {8'd0, scale_ff};
            y_in       = base_y_ff;
         end else begin
            row_cnt_in = row_cnt_ff + 3'd1;
            y_in       = y_ff + {8'd0, scale_ff};
         end
         if (gen_last) begin
            busy_in = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         if (req_word.first) begin
            origin_col_in = req_word.start_x;
         end
         if (is_newline) begin
            cursor_row_in = eff_row + {5'd0, scale_ff, 3'b000} + 16'd2;
            cursor_col_in = req_word.first ? req_word.start_x : origin_col_ff;
         end else begin
            cursor_row_in = eff_row;
            cursor_col_in = eff_col + {5'd0, advance};
            busy_in       = 1'b1;
            col_cnt_in    = 3'd0;
            row_cnt_in    = 3'd0;
            x_in          = eff_col;
            y_in          = eff_row;
            base_y_in     = eff_row;
            glyph_in      = glyph_ordered;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff   <= 16'hFFFF;
         bg_color_ff   <= 16'h0000;
         scale_ff      <= 8'd1;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         origin_col_ff <= '0;
         busy_ff       <= 1'b0;
         col_cnt_ff    <= '0;
         row_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CsrForegroundColor: fg_color_ff <= csr_wdata;
               CsrBackgroundColor: bg_color_ff <= csr_wdata;
               CsrPixelScale:      scale_ff    <= csr_wdata[7:0];
               default:            ;   // drop writes to unused indexes
            endcase
         end
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         origin_col_ff <= origin_col_in;
         busy_ff       <= busy_in;
         col_cnt_ff    <= col_cnt_in;
         row_cnt_ff    <= row_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      base_y_ff   <= base_y_in;
      glyph_ff    <= glyph_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ----- sim/glyph_cell_checker.sv -----
// Cell checker for the scaled glyph text renderer: mirrors cursor, origin and
// the color/scale registers, predicts forty cell words per character (none for a newline), compares in order.
// Depends on sgtr_pkg.
`timescale 1ns / 100ps

module glyph_cell_checker
   import sgtr_pkg::*;
#(
   parameter int unsigned SCREEN_WIDTH  = 320,
   parameter int unsigned SCREEN_HEIGHT = 480
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire req_word_type             req_word,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire rsp_word_type             rsp_word,
   input  wire logic                     csr_wr_en,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata,
   output int                            failures,
   output int                            cells_pending
);

   localparam logic [7:0] QuestionMark = 8'd63;
   localparam int         CellsPerChar = 40;
   localparam int         MaxReports   = 10;

   // Glyph for code 32 in the top 40 bits, code 122 in the bottom 40.
   // Within a glyph, column 0 is the top byte; bit 0 of a byte is the top row.
   localparam logic [91*40-1:0] FontColumns = {
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
      40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
      40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44
   };

   logic [15:0]  fg_color;
   logic [15:0]  bg_color;
   logic [7:0]   pixel_scale;
   logic [15:0]  cursor_col;
   logic [15:0]  cursor_row;
   logic [15:0]  origin_col;
   rsp_word_type expected_cells[$];

   task automatic predict_char(input req_word_type w);
      logic [7:0]   code;
      logic [39:0]  glyph;
      logic [7:0]   column_bits;
      logic [31:0]  x;
      logic [31:0]  y;
      int unsigned  base;
      int           col;
      int           row;
      int           cell_idx;
      rsp_word_type cell_word;
      if (w.first) begin
         cursor_col = w.start_x;
         origin_col = w.start_x;
         cursor_row = w.start_y;
      end
      if (w.char_code == NewlineCode) begin
         cursor_row = cursor_row + {5'd0, pixel_scale, 3'd0} + 16'd2;
         cursor_col = origin_col;
      end else begin
         code = (w.char_code < GlyphFirst || w.char_code > GlyphLast) ? QuestionMark
                                                                      : w.char_code;
         base = (GlyphLast - code) * 40;
         glyph = FontColumns[base +: 40];
         cell_idx = 0;
         for (col = 0; col < 5; col++) begin
            column_bits = glyph[(4 - col) * 8 +: 8];
            x = (cursor_col + col * pixel_scale) & 32'hFFFF;
            for (row = 0; row < 8; row++) begin
               y = (cursor_row + row * pixel_scale) & 32'hFFFF;
               cell_word.cell_x = x[15:0];
               cell_word.cell_y = y[15:0];
               cell_word.visible = (x < SCREEN_WIDTH) && (y < SCREEN_HEIGHT) &&
                                   (pixel_scale != 0);
               if (!cell_word.visible) begin
                  cell_word.cell_width  = 8'd0;
                  cell_word.cell_height = 8'd0;
               end else begin
                  cell_word.cell_width  = (x + pixel_scale > SCREEN_WIDTH)
                                          ? 8'(SCREEN_WIDTH - x) : pixel_scale;
                  cell_word.cell_height = (y + pixel_scale > SCREEN_HEIGHT)
                                          ? 8'(SCREEN_HEIGHT - y) : pixel_scale;
               end
               cell_word.cell_color = column_bits[row] ? fg_color : bg_color;
               cell_word.last_cell  = (cell_idx == CellsPerChar - 1);
               expected_cells.push_back(cell_word);
               cell_idx++;
            end
         end
         // zero scale leaves the cursor where it is
         cursor_col = 16'(cursor_col + 6 * pixel_scale);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         fg_color    = 16'hFFFF;
         bg_color    = 16'h0000;
         pixel_scale = 8'd1;
         cursor_col  = 16'd0;
         cursor_row  = 16'd0;
         origin_col  = 16'd0;
         expected_cells.delete();
         failures = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CsrForegroundColor: fg_color = csr_wdata;
               CsrBackgroundColor: bg_color = csr_wdata;
               CsrPixelScale:      pixel_scale = csr_wdata[7:0];
               default: ;   // drop writes to unused indexes
            endcase
         end
         if (req_valid && req_ready)
            predict_char(req_word);
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               if (failures < MaxReports)
                  $display("unexpected cell word x=%0d y=%0d", rsp_word.cell_x, rsp_word.cell_y);
               failures++;
            end else begin
               want = expected_cells.pop_front();
               if (want.cell_x !== rsp_word.cell_x || want.cell_y !== rsp_word.cell_y ||
                   want.cell_width !== rsp_word.cell_width ||
                   want.cell_height !== rsp_word.cell_height ||
                   want.cell_color !== rsp_word.cell_color ||
                   want.visible !== rsp_word.visible || want.last_cell !== rsp_word.last_cell)
               begin
                  if (failures < MaxReports) begin
                     $display({"cell mismatch: expected x=%0d y=%0d w=%0d h=%0d ",
                               "color=%h vis=%b last=%b"},
                              want.cell_x, want.cell_y, want.cell_width, want.cell_height,
                              want.cell_color, want.visible, want.last_cell);
                     $display({"               got      x=%0d y=%0d w=%0d h=%0d ",
                               "color=%h vis=%b last=%b"},
                              rsp_word.cell_x, rsp_word.cell_y, rsp_word.cell_width,
                              rsp_word.cell_height, rsp_word.cell_color, rsp_word.visible,
                              rsp_word.last_cell);
                  end
                  failures++;
               end
            end
         end
      end
      cells_pending <= expected_cells.size();
   end

endmodule

// ----- sim/scaled_glyph_text_renderer_tb.sv -----
// Top of the text renderer bench: clock, reset, character and register stimulus,
// randomized sender and receiver gaps, watchdog and verdict.
// Depends on sgtr_pkg, scaled_glyph_text_renderer and glyph_cell_checker.
`timescale 1ns / 100ps

module scaled_glyph_text_renderer_tb;
   import sgtr_pkg::*;

   localparam int unsigned ScreenWidth    = 320;
   localparam int unsigned ScreenHeight   = 480;
   localparam int          IdleLimit      = 3000;
   localparam int          SinkHoldCycles = 400;
   localparam int          RandomPerPhase = 25;
   localparam logic [CsrIndexWidth-1:0] CsrUnused = 2'd3;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_word_type             req_word;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_word_type             rsp_word;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;
   int                       failures;
   int                       cells_pending;
   int                       idle_cycles = 0;
   bit                       sink_hold_start;
   bit                       sink_hold_done;

   scaled_glyph_text_renderer #(
      .SCREEN_WIDTH(ScreenWidth),
      .SCREEN_HEIGHT(ScreenHeight)
   ) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   glyph_cell_checker #(
      .SCREEN_WIDTH(ScreenWidth),
      .SCREEN_HEIGHT(ScreenHeight)
   ) cell_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .cells_pending(cells_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_word_type char_word(input logic [7:0] code, input logic first,
                                              input logic [15:0] sx, input logic [15:0] sy);
      req_word_type w;
      w.char_code = code;
      w.first     = first;
      w.start_x   = sx;
      w.start_y   = sy;
      return w;
   endfunction

   // printable text with occasional newlines, string starts and junk codes
   function automatic req_word_type random_char_word();
      int           r;
      logic [7:0]   code;
      logic [15:0]  sx;
      logic [15:0]  sy;
      r = $urandom_range(0, 99);
      if (r < 70)      code = 8'($urandom_range(GlyphFirst, GlyphLast));
      else if (r < 80) code = NewlineCode;
      else             code = 8'($urandom_range(0, 255));
      sx = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 340));
      sy = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 500));
      return char_word(code, $urandom_range(0, 6) == 0, sx, sy);
   endfunction

   task automatic offer_char(input req_word_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic offer_random(input int count);
      int i;
      for (i = 0; i < count; i++)
         offer_char(random_char_word());
   endtask

   // hold off until every cell is back, then let a trailing newline settle
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (cells_pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_regs(input logic [15:0] fg, input logic [15:0] bg,
                            input logic [7:0] scale);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      write_reg(CsrForegroundColor, fg);
      write_reg(CsrBackgroundColor, bg);
      write_reg(CsrPixelScale, {junk, scale});
      csr_wr_en <= 1'b0;
   endtask

   // receiver: random ready pattern, plus one long hold-off on request
   initial begin
      int run_len;
      int stall_len;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (sink_hold_start && !sink_hold_done) begin
            rsp_ready <= 1'b0;
            repeat (SinkHoldCycles) @(posedge clock);
            sink_hold_done = 1'b1;
         end
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         stall_len = pick_gap();
         if (stall_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_word        = '0;
      csr_wr_en       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      sink_hold_start = 1'b0;
      sink_hold_done  = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // register defaults straight out of reset
      offer_char(char_word(8'd65, 1'b1, 16'd0, 16'd0));
      offer_char(char_word(8'd32, 1'b0, 16'd0, 16'd0));
      offer_char(char_word(8'd122, 1'b0, 16'd0, 16'd0));
      offer_char(char_word(8'd31, 1'b0, 16'd0, 16'd0));
      offer_char(char_word(8'd123, 1'b0, 16'd0, 16'd0));
      offer_char(char_word(8'd0, 1'b0, 16'd0, 16'd0));
      offer_char(char_word(8'd255, 1'b0, 16'd0, 16'd0));
      offer_char(char_word(8'd128, 1'b0, 16'd0, 16'd0));
      // start fields must be ignored without the first flag
      offer_char(char_word(NewlineCode, 1'b0, 16'hFFFF, 16'hFFFF));
      offer_char(char_word(8'd48, 1'b0, 16'hFFFF, 16'hFFFF));
      // glyph straddling the right and bottom screen edges
      offer_char(char_word(8'd35, 1'b1, 16'd316, 16'd474));
      // cursor wraps past 65535
      offer_char(char_word(8'd87, 1'b1, 16'hFFFF, 16'hFFFF));
      offer_char(char_word(NewlineCode, 1'b1, 16'd100, 16'd200));
      offer_char(char_word(8'd77, 1'b0, 16'd0, 16'd0));
      drain_results();

      // zero scale, swapped colors, and a write to an unused index
      write_reg(CsrUnused, 16'hFFFF);
      load_regs(16'h0000, 16'hFFFF, 8'd0);
      offer_char(char_word(8'd66, 1'b1, 16'd10, 16'd10));
      offer_char(char_word(NewlineCode, 1'b0, 16'd0, 16'd0));
      offer_char(char_word(8'd67, 1'b0, 16'd0, 16'd0));
      drain_results();

      // largest scale: cells clip and run off screen
      load_regs(16'h5A5A, 16'hA5A5, 8'd255);
      offer_char(char_word(8'd64, 1'b1, 16'd0, 16'd0));
      offer_char(char_word(8'd37, 1'b0, 16'd0, 16'd0));
      offer_char(char_word(NewlineCode, 1'b0, 16'd0, 16'd0));
      offer_char(char_word(8'd103, 1'b1, 16'd200, 16'd300));
      drain_results();

      load_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 8'd3);
      offer_char(char_word(8'd72, 1'b1, 16'd318, 16'd478));
      offer_random(RandomPerPhase);
      drain_results();

      // receiver holds off while characters keep coming
      load_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 8'd1);
      sink_hold_start = 1'b1;
      offer_random(RandomPerPhase);
      drain_results();

      load_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                8'($urandom_range(2, 8)));
      offer_random(RandomPerPhase);
      drain_results();

      load_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                8'($urandom_range(0, 255)));
      offer_random(RandomPerPhase);
      drain_results();

      if (failures == 0 && cells_pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
